[rtl/oaht_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_pkg
// Types and constants shared by the open addressing hash table modules.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // field widths of the request and response transfers
    localparam int KEY_W    = 31;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // request operations
    typedef enum logic [OP_W-1:0] {
        OP_INS_LIN  = 2'd0,
        OP_INS_QUAD = 2'd1,
        OP_SEARCH   = 2'd2,
        OP_DELETE   = 2'd3
    } t_op;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK   = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } t_status;

    // request payload
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } t_req;

    // response payload
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } t_rsp;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_HOME,
        S_READ,
        S_CHECK,
        S_WRITE,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic    load;
        logic    hash_step;
        logic    probe_init;
        logic    probe_next;
        logic    clear_wr;
        logic    slot_wr;
        logic    res_load;
        t_status res_status;
        logic    out_load;
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic addr_last;
        logic probe_last;
        logic probe_empty;
        logic probe_match;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/oaht_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_dp
// Datapath: home slot reduction, probe address sequencing, slot store and
// response register.
// ----------------------------------------------------------------------------
module oaht_dp
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_rsp    o_out_data
);

    localparam int SW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int RW = SW + 1;
    localparam int XW = (SW > SLOT_W) ? SW : SLOT_W;
    localparam int MW = 32;
    localparam int PW = KEY_W + MW;
    localparam logic [RW-1:0] N_R    = RW'(TABLE_SIZE);
    localparam logic [SW-1:0] N_S    = SW'(TABLE_SIZE);
    localparam logic [SW-1:0] LAST_S = SW'(TABLE_SIZE - 1);
    // table size reciprocal rounded up, scaled by 2^(KEY_W+SW), exact quotient
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << (KEY_W + SW)) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE));

    // slot store: valid mark above the key
    logic [KEY_W:0] r_slot_mem [TABLE_SIZE];
    logic [KEY_W:0] r_rd_word;
    logic [KEY_W:0] mem_wdata;
    logic           mem_we;

    logic [OP_W-1:0]      r_op;
    logic [KEY_W-1:0]     r_key;
    logic [SW-1:0]        r_quot;
    logic [SW-1:0]        r_addr;
    logic [SW-1:0]        r_cnt;
    logic [SW-1:0]        r_dist;
    logic [STATUS_W-1:0]  r_res_status;
    logic [SLOT_W-1:0]    r_res_slot;
    logic                 r_out_valid;
    t_rsp                 r_out_data;

    logic [SW-1:0] n_rem;
    logic [SW-1:0] n_addr;
    logic [SW-1:0] n_dist;
    logic [SW-1:0] lin_addr;
    logic [RW-1:0] quad_sum;
    logic [RW-1:0] dist_sum;
    logic [XW-1:0] addr_ext;
    logic          is_insert;

    assign is_insert = (r_op == OP_INS_LIN) || (r_op == OP_INS_QUAD);

    // home slot from the low quotient bits, only the low SW bits matter
    assign n_rem = r_key[SW-1:0] - r_quot * N_S;

    // next probe address, linear or by growing odd steps for quadratic
    always_comb begin
        lin_addr = (r_addr == LAST_S) ? '0 : r_addr + 1'b1;
        quad_sum = {1'b0, r_addr} + {1'b0, r_dist};
        if (quad_sum >= N_R) begin
            quad_sum = quad_sum - N_R;
        end
        dist_sum = {1'b0, r_dist} + RW'(2);
        if (dist_sum >= N_R) begin
            dist_sum = dist_sum - N_R;
        end
        n_dist = dist_sum[SW-1:0];
        n_addr = (r_op == OP_INS_QUAD) ? quad_sum[SW-1:0] : lin_addr;
    end

    // request capture and quotient by reciprocal multiply
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_req.op;
            r_key <= i_req.key;
        end
        if (i_cmd.hash_step) begin
            r_quot <= SW'((PW'(r_key) * PW'(RECIP)) >> (KEY_W + SW));
        end
    end

    // probe address, probe count and quadratic step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_cnt  <= '0;
            r_dist <= '0;
        end else if (i_cmd.clear_wr) begin
            r_addr <= lin_addr;
        end else if (i_cmd.probe_init) begin
            r_addr <= n_rem;
            r_cnt  <= '0;
            r_dist <= SW'(1);
        end else if (i_cmd.probe_next) begin
            r_addr <= n_addr;
            r_cnt  <= r_cnt + 1'b1;
            r_dist <= n_dist;
        end
    end

    // slot store with registered read
    assign mem_we    = i_cmd.clear_wr || i_cmd.slot_wr;
    assign mem_wdata = i_cmd.clear_wr ? '0 : {is_insert, r_key};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_mem[r_addr] <= mem_wdata;
        end
        r_rd_word <= r_slot_mem[r_addr];
    end

    // result capture, slot only reported on success
    assign addr_ext = XW'(r_addr);

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_slot   <= (i_cmd.res_status == STAT_OK) ? addr_ext[SLOT_W-1:0] : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.status <= r_res_status;
            r_out_data.slot   <= r_res_slot;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // status to the controller
    assign o_sts.is_insert   = is_insert;
    assign o_sts.is_delete   = (r_op == OP_DELETE);
    assign o_sts.addr_last   = (r_addr == LAST_S);
    assign o_sts.probe_last  = (r_cnt == LAST_S);
    assign o_sts.probe_empty = !r_rd_word[KEY_W];
    assign o_sts.probe_match = (r_rd_word[KEY_W-1:0] == r_key);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

endmodule

[rtl/oaht_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// oaht_ctrl
// Controller: sequences store clearing, home slot reduction, probing,
// writeback and response hand-off.
// ----------------------------------------------------------------------------
module oaht_ctrl
    import oaht_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.addr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_HASH;
                end
            end
            S_HASH:  n_state = S_HOME;
            S_HOME:  n_state = S_READ;
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                priority if (i_sts.is_insert) begin
                    if (i_sts.probe_empty) begin
                        n_state = S_WRITE;
                    end else if (i_sts.probe_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end else if (i_sts.probe_empty) begin
                    n_state = S_DONE;
                end else if (i_sts.probe_match) begin
                    n_state = i_sts.is_delete ? S_WRITE : S_DONE;
                end else if (i_sts.probe_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_WRITE: n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // datapath commands
    always_comb begin
        o_cmd            = '0;
        o_cmd.res_status = STAT_OK;
        o_in_stall       = 1'b1;
        unique case (r_state)
            S_CLEAR: o_cmd.clear_wr = 1'b1;
            S_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            S_HASH:  o_cmd.hash_step  = 1'b1;
            S_HOME:  o_cmd.probe_init = 1'b1;
            S_READ:  ;
            S_CHECK: begin
                priority if (i_sts.is_insert) begin
                    if (i_sts.probe_empty) begin
                        o_cmd.res_load = 1'b1;
                    end else if (i_sts.probe_last) begin
                        o_cmd.res_load   = 1'b1;
                        o_cmd.res_status = STAT_FULL;
                    end else begin
                        o_cmd.probe_next = 1'b1;
                    end
                end else if (i_sts.probe_empty) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STAT_MISS;
                end else if (i_sts.probe_match) begin
                    o_cmd.res_load = 1'b1;
                end else if (i_sts.probe_last) begin
                    o_cmd.res_load   = 1'b1;
                    o_cmd.res_status = STAT_MISS;
                end else begin
                    o_cmd.probe_next = 1'b1;
                end
            end
            S_WRITE: o_cmd.slot_wr  = 1'b1;
            S_DONE:  o_cmd.out_load = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

[rtl/open_addressing_hash_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// open_addressing_hash_table
// Open addressing hash table with linear and quadratic insert, linear
// search and delete over TABLE_SIZE key slots.
// ----------------------------------------------------------------------------
//  channel   valid        stall         payload
//  request   i_in_valid   o_in_stall    i_in_data  (t_req: op, key)
//  response  o_out_valid  i_out_stall   o_out_data (t_rsp: status, slot)
//
//  a response is loaded after its request passes the home slot quotient by
//  reciprocal multiply, the home slot, a read and a check for each slot probed
//  (1 to TABLE_SIZE slots), then a writeback if one is needed; the next request
//  can be taken in the cycle after the load, so requests are handled one at a
//  time, and a stalled response delays the load
//  after reset the store is cleared slot by slot, requests stalled
// ----------------------------------------------------------------------------
module open_addressing_hash_table
    import oaht_pkg::*;
#(
    parameter int TABLE_SIZE = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // sequencing
    oaht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // hashing, probing and slot store
    oaht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_data),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
